FILE: hw/rtl/lfo_waveform_generator_top_assert.svh
// Assertion macros shared by the LFO waveform generator modules.
`ifndef LFO_WAVEFORM_GENERATOR_TOP_ASSERT_SVH
`define LFO_WAVEFORM_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define LFO_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("lfo_waveform_generator: implication check failed");
`define LFO_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("lfo_waveform_generator: next-cycle check failed");
`else
`define LFO_ASSERT_IMP(lbl, ant, cons)
`define LFO_ASSERT_NEXT(lbl, ant, cons)
`endif

`endif

FILE: hw/rtl/lfo_pkg.sv
// Shared types and constants of the LFO waveform generator.
`timescale 1ns / 1ps

package lfo_pkg;

    localparam int LFO_LEN     = 64;
    localparam int TABLE_DEPTH = 256;
    localparam int LEN_BITS    = $clog2(LFO_LEN);
    localparam int HALF_LEN    = LFO_LEN / 2;
    localparam int HALF_BITS   = $clog2(HALF_LEN);
    localparam int TBL_BITS    = $clog2(TABLE_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WAVE_SHAPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_AMPLITUDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECAY_RATE = 2'd2;

    typedef enum logic [2:0] {
        SHAPE_ZERO     = 3'd0,
        SHAPE_EXP      = 3'd1,
        SHAPE_INV_EXP  = 3'd2,
        SHAPE_RAMP     = 3'd3,
        SHAPE_INV_RAMP = 3'd4,
        SHAPE_TRIANGLE = 3'd5,
        SHAPE_COSINE   = 3'd6
    } shape_t;

    typedef struct packed {
        logic [2:0]  shape_code;
        logic [7:0]  amplitude;
        logic [15:0] decay_rate;
    } cfg_t;

    typedef struct packed {
        shape_t      shape;
        logic [7:0]  amp;
        logic [7:0]  index;
        logic [23:0] decay_pos;
        logic [15:0] amp_idx;
        logic [15:0] amp_fall;
    } job_t;

    typedef struct packed {
        logic empty;
        logic no_room;
    } queue_status_t;

endpackage

FILE: hw/rtl/lfo_queue.sv
// Short item queue between the front and back parts of the LFO generator.
`timescale 1ns / 1ps
`include "lfo_waveform_generator_top_assert.svh"

module lfo_queue
    import lfo_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    output job_t          head,
    output queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    // The back part drains one item every cycle whenever one is present.
    assign pop  = (count_reg != '0);
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // An item accepted now lands here only after the front register, so room is judged on the next count.
    assign status.empty   = (count_reg == '0);
    assign status.no_room = (count_next >= CNT_W'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `LFO_ASSERT_IMP(a_queue_no_overflow, push, count_reg < CNT_W'(DEPTH))
    `LFO_ASSERT_IMP(a_queue_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

FILE: hw/rtl/lfo_front.sv
// Front part: accepts sample indexes, classifies the shape and forms the index products.
`timescale 1ns / 1ps

module lfo_front
    import lfo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       no_room,
    input  logic [7:0] sample_index,
    input  cfg_t       cfg,
    output logic       job_valid,
    output job_t       job
);

    logic   accept;
    logic   valid_reg;
    job_t   job_reg;
    job_t   job_next;
    shape_t shape;

    assign accept = start && !no_room;

    always_comb
    begin
        priority if (cfg.shape_code > 3'(SHAPE_COSINE))
        begin
            shape = SHAPE_ZERO;
        end
        else
        begin
            shape = shape_t'(cfg.shape_code);
        end
    end

    always_comb
    begin
        job_next.shape     = shape;
        job_next.amp       = cfg.amplitude;
        job_next.index     = sample_index;
        job_next.decay_pos = 24'(sample_index) * 24'(cfg.decay_rate);
        job_next.amp_idx   = 16'(cfg.amplitude) * 16'(sample_index);
        if (sample_index > 8'(HALF_LEN))
        begin
            job_next.amp_fall = 16'(cfg.amplitude) * 16'(sample_index - 8'(HALF_LEN));
        end
        else
        begin
            job_next.amp_fall = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    assign job_valid = valid_reg;
    assign job       = job_reg;

endmodule

FILE: hw/rtl/lfo_back.sv
// Back part: table lookups, scaling and final selection of the waveform value.
`timescale 1ns / 1ps
`include "lfo_waveform_generator_top_assert.svh"

module lfo_back
    import lfo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head,
    output logic       done,
    output logic [7:0] wave_value
);

    typedef logic [16:0] rom_t [TABLE_DEPTH];

    localparam longint     Q30_ONE       = 64'sd1073741824;
    localparam logic [63:0] Q30_TWO_PI   = 64'd6746518852;
    localparam logic [63:0] Q30_PI       = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
    localparam logic [7:0]  EXP_INT_LIMIT = 8'd12;

    // Shift-and-subtract quotient, used only while the tables are built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= 65'(den))
            begin
                rem    = rem - 65'(den);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic longint cos_q30(input logic [63:0] a);
        longint      sum;
        logic [63:0] term;
        sum  = Q30_ONE;
        term = 64'(Q30_ONE);
        for (int m = 1; m <= 14; m++)
        begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = udiv64(term, 64'((2 * m - 1) * (2 * m)));
            if (m % 2 == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > Q30_ONE)
        begin
            sum = Q30_ONE;
        end
        return sum;
    endfunction

    function automatic rom_t build_expf();
        rom_t        rom;
        logic [63:0] sum;
        logic [63:0] term;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int m = 1; m <= 24; m++)
            begin
                term = udiv64(term * 64'(j), 64'(TABLE_DEPTH) * 64'(m));
                if (m % 2 == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            rom[j] = 17'((sum + 64'd32768) >> 16);
        end
        return rom;
    endfunction

    function automatic rom_t build_rc();
        rom_t        rom;
        logic [63:0] theta;
        logic        neg;
        longint      c;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            theta = (64'(j) * Q30_TWO_PI) >> TBL_BITS;
            neg   = 1'b0;
            if (theta > Q30_PI)
            begin
                theta = Q30_TWO_PI - theta;
            end
            if (theta > Q30_HALF_PI)
            begin
                theta = Q30_PI - theta;
                neg   = 1'b1;
            end
            c = cos_q30(theta);
            if (neg)
            begin
                c = -c;
            end
            rom[j] = 17'((64'(Q30_ONE - c) + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    function automatic logic [16:0] expi_lookup(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    localparam rom_t EXPF_ROM = build_expf();
    localparam rom_t RC_ROM   = build_rc();

    // Stage 1: table reads and the linear shapes.
    logic [7:0]          exp_int;
    logic [TBL_BITS-1:0] exp_frac_idx;
    logic [TBL_BITS-1:0] cos_idx;
    logic [15:0]         ramp_raw;
    logic [7:0]          ramp8;
    logic [15:0]         rise_raw;
    logic [16:0]         fall_raw;
    logic [7:0]          tri8;
    logic [7:0]          lin_next;

    logic        b1_valid_reg;
    shape_t      b1_shape_reg;
    logic [7:0]  b1_amp_reg;
    logic [16:0] b1_expi_reg;
    logic [16:0] b1_expf_reg;
    logic        b1_exp_zero_reg;
    logic [16:0] b1_rc_reg;
    logic [7:0]  b1_lin_reg;

    assign exp_int      = head.decay_pos[23:16];
    assign exp_frac_idx = head.decay_pos[15:16-TBL_BITS];
    assign cos_idx      = TBL_BITS'(16'(head.index) << (TBL_BITS - LEN_BITS));
    assign ramp_raw     = head.amp_idx >> LEN_BITS;
    assign ramp8        = (ramp_raw > 16'd255) ? 8'd255 : ramp_raw[7:0];
    assign rise_raw     = head.amp_idx >> HALF_BITS;
    assign fall_raw     = (17'(head.amp_fall) + 17'(HALF_LEN - 1)) >> HALF_BITS;

    always_comb
    begin
        priority if (head.index <= 8'(HALF_LEN))
        begin
            tri8 = (rise_raw > 16'd255) ? 8'd255 : rise_raw[7:0];
        end
        else if (fall_raw >= 17'(head.amp))
        begin
            tri8 = 8'd0;
        end
        else
        begin
            tri8 = head.amp - fall_raw[7:0];
        end
    end

    always_comb
    begin
        unique case (head.shape)
            SHAPE_RAMP:     lin_next = ramp8;
            SHAPE_INV_RAMP: lin_next = (ramp8 >= head.amp) ? 8'd0 : head.amp - ramp8;
            SHAPE_TRIANGLE: lin_next = tri8;
            default:        lin_next = 8'd0;
        endcase
    end

    // Stage 2: exponential product and cosine scaling.
    logic [33:0] eprod;
    logic [16:0] e_next;
    logic [24:0] cprod;
    logic [7:0]  cos_next;

    logic        b2_valid_reg;
    shape_t      b2_shape_reg;
    logic [7:0]  b2_amp_reg;
    logic [16:0] b2_e_reg;
    logic [7:0]  b2_cos_reg;
    logic [7:0]  b2_lin_reg;

    assign eprod    = 34'(b1_expi_reg) * 34'(b1_expf_reg) + 34'd32768;
    assign e_next   = b1_exp_zero_reg ? 17'd0 : eprod[32:16];
    assign cprod    = 25'(b1_amp_reg) * 25'(b1_rc_reg);
    assign cos_next = (cprod[24:16] > 9'd255) ? 8'd255 : cprod[23:16];

    // Stage 3: amplitude scaling of the exponential and the final pick.
    logic [24:0] vprod;
    logic [7:0]  ev8;
    logic [7:0]  y_next;
    logic        done_reg;
    logic [7:0]  wave_reg;

    assign vprod = 25'(b2_amp_reg) * 25'(b2_e_reg);
    assign ev8   = (vprod[24:16] > 9'd255) ? 8'd255 : vprod[23:16];

    always_comb
    begin
        unique case (b2_shape_reg)
            SHAPE_EXP:      y_next = ev8;
            SHAPE_INV_EXP:  y_next = (ev8 >= b2_amp_reg) ? 8'd0 : b2_amp_reg - ev8;
            SHAPE_RAMP:     y_next = b2_lin_reg;
            SHAPE_INV_RAMP: y_next = b2_lin_reg;
            SHAPE_TRIANGLE: y_next = b2_lin_reg;
            SHAPE_COSINE:   y_next = b2_cos_reg;
            default:        y_next = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= head_valid;
            b2_valid_reg <= b1_valid_reg;
            done_reg     <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_shape_reg    <= head.shape;
        b1_amp_reg      <= head.amp;
        b1_expi_reg     <= expi_lookup(exp_int[3:0]);
        b1_expf_reg     <= EXPF_ROM[exp_frac_idx];
        b1_exp_zero_reg <= (exp_int >= EXP_INT_LIMIT);
        b1_rc_reg       <= RC_ROM[cos_idx];
        b1_lin_reg      <= lin_next;

        b2_shape_reg <= b1_shape_reg;
        b2_amp_reg   <= b1_amp_reg;
        b2_e_reg     <= e_next;
        b2_cos_reg   <= cos_next;
        b2_lin_reg   <= b1_lin_reg;

        wave_reg <= y_next;
    end

    assign done       = done_reg;
    assign wave_value = wave_reg;

    `LFO_ASSERT_NEXT(a_back_stage_flow, b1_valid_reg, b2_valid_reg)
    `LFO_ASSERT_NEXT(a_back_exp_cutoff, b1_valid_reg && b1_exp_zero_reg, b2_e_reg == 17'd0)

endmodule

FILE: hw/rtl/lfo_waveform_generator_top.sv
// Top level of the LFO waveform generator: configuration registers and part wiring.
`timescale 1ns / 1ps
`include "lfo_waveform_generator_top_assert.svh"

// The block takes one sample index per clock cycle while busy is low and returns one
// waveform value for each item, marked by done for a single cycle. Each item passes the
// front register, the queue slot and the three back stages (table read, exponential
// product, amplitude scaling). The back part drains the queue every cycle, so busy
// stays low in steady operation and results always come out in input order.
// Configuration writes take effect at once and are meant to be made only while no
// item is in flight.
module lfo_waveform_generator_top
    import lfo_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           sample_index,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output logic                 done,
    output logic [7:0]           wave_value
);

    localparam int PIPE_LATENCY = 5;

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    queue_status_t q_status;
    logic          job_valid;
    job_t          job;
    job_t          head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDX_WAVE_SHAPE: cfg_next.shape_code = cfg_data[2:0];
                CFG_IDX_AMPLITUDE:  cfg_next.amplitude  = cfg_data[7:0];
                CFG_IDX_DECAY_RATE: cfg_next.decay_rate = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape_code <= 3'(SHAPE_ZERO);
            cfg_reg.amplitude  <= 8'd127;
            cfg_reg.decay_rate <= 16'd2521;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lfo_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .no_room      (q_status.no_room),
        .sample_index (sample_index),
        .cfg          (cfg_reg),
        .job_valid    (job_valid),
        .job          (job)
    );

    lfo_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .head     (head),
        .status   (q_status)
    );

    lfo_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_status.empty),
        .head       (head),
        .done       (done),
        .wave_value (wave_value)
    );

    assign busy = q_status.no_room;

    `LFO_ASSERT_IMP(a_top_fixed_latency, start && !busy, 1'b1 ##PIPE_LATENCY done)

endmodule

FILE: sim/lfo_waveform_generator_tb.sv
// Self-checking testbench of the LFO waveform generator with its scoreboard.
`timescale 1ns / 1ps

module tb;
    import lfo_pkg::*;

    localparam longint ONE_Q30 = 64'd1073741824;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned EXP_INT [12] = '{
        65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1
    };

    class lfo_scoreboard;
        logic [2:0] shape_code;
        logic [7:0] amp;
        logic [15:0] decay;
        longint unsigned exp_frac_rom [TABLE_DEPTH];
        longint unsigned cos_rom [TABLE_DEPTH];
        logic [7:0] pending_values [$];
        int errors;

        function new();
            longint unsigned sum;
            longint unsigned term;
            longint unsigned theta;
            longint c;
            bit neg;
            shape_code = SHAPE_ZERO;
            amp = 8'd127;
            decay = 16'd2521;
            errors = 0;
            for (int j = 0; j < TABLE_DEPTH; j++)
            begin
                sum = 64'd1 << 32;
                term = 64'd1 << 32;
                for (int m = 1; m <= 24; m++)
                begin
                    term = term * 64'(j) / 64'(TABLE_DEPTH * m);
                    if (m % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                exp_frac_rom[j] = (sum + 64'd32768) >> 16;

                theta = 64'(j) * TWO_PI_Q30 / 64'(TABLE_DEPTH);
                neg = 1'b0;
                if (theta > PI_Q30)
                    theta = TWO_PI_Q30 - theta;
                if (theta > HALF_PI_Q30)
                begin
                    theta = PI_Q30 - theta;
                    neg = 1'b1;
                end
                c = ONE_Q30;
                term = 64'(ONE_Q30);
                for (int m = 1; m <= 14; m++)
                begin
                    term = (term * theta) >> 30;
                    term = (term * theta) >> 30;
                    term = term / 64'((2 * m - 1) * (2 * m));
                    if (m % 2 == 1)
                        c = c - longint'(term);
                    else
                        c = c + longint'(term);
                end
                if (c < 0)
                    c = 0;
                if (c > ONE_Q30)
                    c = ONE_Q30;
                if (neg)
                    c = -c;
                cos_rom[j] = 64'((ONE_Q30 - c) + 64'sd16384) >> 15;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                CFG_IDX_WAVE_SHAPE: shape_code = data[2:0];
                CFG_IDX_AMPLITUDE:  amp = data[7:0];
                CFG_IDX_DECAY_RATE: decay = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] lfo_value(logic [7:0] n);
            longint unsigned x;
            longint unsigned e;
            longint unsigned v;
            longint unsigned d;
            longint unsigned h;
            longint unsigned a;
            h = 64'(HALF_LEN);
            a = 64'(amp);
            v = 0;
            case (shape_code)
                SHAPE_EXP, SHAPE_INV_EXP:
                begin
                    x = 64'(n) * 64'(decay);
                    if ((x >> 16) >= 12)
                        e = 0;
                    else
                        e = (EXP_INT[x >> 16]
                             * exp_frac_rom[((x & 64'hFFFF) * 64'(TABLE_DEPTH)) >> 16]
                             + 64'd32768) >> 16;
                    v = (a * e) >> 16;
                    if (shape_code == SHAPE_INV_EXP)
                        v = (v >= a) ? 0 : a - v;
                end
                SHAPE_RAMP, SHAPE_INV_RAMP:
                begin
                    v = a * 64'(n) / 64'(LFO_LEN);
                    if (v > 255)
                        v = 255;
                    if (shape_code == SHAPE_INV_RAMP)
                        v = (v >= a) ? 0 : a - v;
                end
                SHAPE_TRIANGLE:
                begin
                    if (64'(n) <= h)
                        v = a * 64'(n) / h;
                    else
                    begin
                        d = (a * (64'(n) - h) + h - 1) / h;
                        v = (d >= a) ? 0 : a - d;
                    end
                end
                SHAPE_COSINE:
                    v = (a * cos_rom[(64'(n) * 64'(TABLE_DEPTH) / 64'(LFO_LEN))
                                     % 64'(TABLE_DEPTH)]) >> 16;
                default: v = 0;
            endcase
            if (v > 255)
                v = 255;
            return v[7:0];
        endfunction

        function void note_item(logic [7:0] n);
            pending_values.push_back(lfo_value(n));
        endfunction

        function void check_value(logic [7:0] got);
            logic [7:0] want;
            if (pending_values.size() == 0)
            begin
                $error("wave_value: expected none, actual %0d", got);
                errors++;
            end
            else
            begin
                want = pending_values.pop_front();
                if (got !== want)
                begin
                    $error("wave_value: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [7:0]           sample_index;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 done;
    logic [7:0]           wave_value;

    lfo_scoreboard sb;

    lfo_waveform_generator_top u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .sample_index (sample_index),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .wave_value   (wave_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                sb.write_reg(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_item(sample_index);
            if (done)
                sb.check_value(wave_value);
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic drive_item(input logic [7:0] n);
        start <= 1'b1;
        sample_index <= n;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [2:0] shape, input logic [7:0] a,
                              input logic [15:0] k);
        while (sb.pending_values.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_IDX_WAVE_SHAPE;
        cfg_data <= {13'd0, shape};
        @(negedge clk);
        cfg_index <= CFG_IDX_AMPLITUDE;
        cfg_data <= {8'd0, a};
        @(negedge clk);
        cfg_index <= CFG_IDX_DECAY_RATE;
        cfg_data <= k;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_items(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    sample_index <= 8'($urandom);
                    repeat (gap) @(negedge clk);
                end
            end
            burst--;
            if ($urandom_range(0, 99) < 85)
                drive_item(8'($urandom_range(0, LFO_LEN - 1)));
            else
                drive_item(8'($urandom_range(0, 255)));
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [2:0] shape;
        logic [7:0] a;
        logic [15:0] k;
        rst_n = 1'b0;
        start = 1'b0;
        sample_index = 8'd0;
        cfg_write = 1'b0;
        cfg_index = CFG_IDX_WAVE_SHAPE;
        cfg_data = 16'd0;
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration, then every shape at the start, the peak and far past the period.
        drive_item(8'd0);
        drive_item(8'd255);
        start <= 1'b0;
        for (int s = SHAPE_EXP; s <= 7; s++)
        begin
            set_config(3'(s), 8'd255, 16'd2521);
            drive_item(8'd0);
            drive_item(8'd32);
            drive_item(8'd200);
            start <= 1'b0;
        end

        for (int p = 0; p < 20; p++)
        begin
            shape = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            case (p % 4)
                0: a = 8'd0;
                1: a = 8'd255;
                default: a = 8'($urandom);
            endcase
            case (p % 5)
                0: k = 16'd0;
                1: k = 16'hFFFF;
                2: k = 16'($urandom_range(0, 4000));
                default: k = 16'($urandom);
            endcase
            set_config(shape, a, k);
            run_items(25);
        end

        while (sb.pending_values.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
